@@ hdl/plc_pkg.sv @@
// Package for the positional list engine: operation codes, status codes,
// cell command type and the control group broadcast along the cell chain.
// No dependencies.
package plc_pkg;

    // operation codes of an input item
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_DELETE = 2'd1;
    localparam logic [1:0] FN_DUMP   = 2'd2;

    // status codes of a result item
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    // index fields sized for the largest supported depth (64)
    localparam int SEL_W = 7;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [SEL_W-1:0]   sel;   // target index for insert/delete
        logic [SEL_W-1:0]   last;  // tail index for rotate
    } cell_ctrl_t;

endpackage

@@ hdl/positional_list_engine_unit.sv @@
// Top level of the positional list engine: handshake, operation decode,
// result register and dump sequencer around the cell chain.
// Depends on plc_pkg and plc_chain.
//
// Usage: the s_ channel carries one operation per item (insert at a
// 1-based position, delete at a position, dump). The m_ channel returns
// result items: one for insert, delete, an unused code or a dump of an
// empty list, and one per stored entry (head first) for a dump;
// m_last_flag marks the final result of each item.
// Timing: a single result is presented the cycle after its item is
// accepted; a dump first enters the rotation without a result, then
// hands out one entry per cycle while the output slot is free.
// Insert and delete are accepted at one item per cycle while m_ready is
// high, since the whole chain shifts in the accept cycle; a dump holds
// s_ready low while the chain rotates once, handing out the head cell
// each cycle that the output slot is free.
// A single output register separates the channels; when m_ready is low
// the result holds and s_ready drops until the slot frees.
// Reset (aresetn low, synchronous) empties the list and drops m_valid;
// no clearing pass is needed because only occupied cells are ever read.
module positional_list_engine_unit
    import plc_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [5:0]  s_position,
    input  logic [31:0] s_item_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_read_value,
    output logic [4:0]  m_entry_total,
    output logic        m_last_flag
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   dump_idx_reg, dump_idx_next;
    logic               m_valid_reg, m_valid_next;
    logic [1:0]         m_status_reg, m_status_next;
    logic [31:0]        m_read_value_reg, m_read_value_next;
    logic [4:0]         m_entry_total_reg, m_entry_total_next;
    logic               m_last_flag_reg, m_last_flag_next;

    cell_ctrl_t            ctrl;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [DATA_WIDTH-1:0] head_data;
    logic [IDX_W-1:0]      rd_idx;
    logic                  slot_free;
    logic                  accept;
    logic [7:0]            pos8;
    logic [7:0]            cnt8;
    logic                  emit;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && slot_free;
    assign accept    = s_valid && s_ready;
    assign pos8      = 8'(s_position);
    assign cnt8      = 8'(count_reg);
    assign rd_idx    = IDX_W'(pos8 - 8'd1);

    always_comb begin
        state_next         = state_reg;
        count_next         = count_reg;
        dump_idx_next      = dump_idx_reg;
        ctrl.op            = CELL_HOLD;
        ctrl.sel           = SEL_W'(pos8 - 8'd1);
        ctrl.last          = SEL_W'(cnt8 - 8'd1);
        emit               = 1'b0;
        m_status_next      = m_status_reg;
        m_read_value_next  = m_read_value_reg;
        m_last_flag_next   = m_last_flag_reg;

        if (accept) begin
            emit              = 1'b1;
            m_status_next     = ST_INVALID;
            m_read_value_next = '0;
            m_last_flag_next  = 1'b1;
            case (s_func)
                FN_INSERT: begin
                    if (count_reg == CNT_FULL) begin
                        m_status_next = ST_FULL;
                    end else if (pos8 != 8'd0 && pos8 <= cnt8 + 8'd1) begin
                        m_status_next = ST_OK;
                        ctrl.op       = CELL_INS;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                FN_DELETE: begin
                    if (pos8 != 8'd0 && pos8 <= cnt8) begin
                        m_status_next     = ST_OK;
                        m_read_value_next = 32'(rd_data);
                        ctrl.op           = CELL_DEL;
                        count_next        = count_reg - CNT_W'(1);
                    end
                end
                FN_DUMP: begin
                    if (count_reg == '0) begin
                        m_status_next = ST_EMPTY;
                    end else begin
                        emit          = 1'b0;
                        state_next    = S_DUMP;
                        dump_idx_next = '0;
                    end
                end
                default: m_status_next = ST_INVALID;
            endcase
        end else if (state_reg == S_DUMP && slot_free) begin
            // hand out the head and rotate it to the tail
            emit              = 1'b1;
            ctrl.op           = CELL_ROT;
            m_status_next     = ST_OK;
            m_read_value_next = 32'(head_data);
            m_last_flag_next  = 8'(dump_idx_reg) == cnt8 - 8'd1;
            dump_idx_next     = dump_idx_reg + IDX_W'(1);
            if (m_last_flag_next) begin
                state_next = S_IDLE;
            end
        end

        m_entry_total_next = emit ? 5'(count_next) : m_entry_total_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            dump_idx_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg      <= m_status_next;
        m_read_value_reg  <= m_read_value_next;
        m_entry_total_reg <= m_entry_total_next;
        m_last_flag_reg   <= m_last_flag_next;
    end

    plc_chain #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_chain (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .new_data  (DATA_WIDTH'(s_item_value)),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data),
        .head_data (head_data)
    );

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_entry_total = m_entry_total_reg;
    assign m_last_flag   = m_last_flag_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("entry count beyond depth");

    a_full_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_func == FN_INSERT && count_reg == CNT_FULL |=> $stable(count_reg))
        else $error("insert into full list changed count");

    a_mid_dump_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_flag |-> state_reg == S_DUMP)
        else $error("non-final result outside dump");

    a_dump_holds_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DUMP |=> $stable(count_reg))
        else $error("count changed during dump");

endmodule

@@ hdl/plc_cell.sv @@
// One storage cell of the list chain: holds one data word and takes it
// from a neighbor, the new value or the head as the broadcast command says.
// Depends on plc_pkg.
module plc_cell
    import plc_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int IDX        = 0
) (
    input  logic                  aclk,
    input  cell_ctrl_t            ctrl,
    input  logic [DATA_WIDTH-1:0] prev_data,
    input  logic [DATA_WIDTH-1:0] next_data,
    input  logic [DATA_WIDTH-1:0] head_data,
    input  logic [DATA_WIDTH-1:0] new_data,
    output logic [DATA_WIDTH-1:0] data_out
);

    localparam logic [SEL_W-1:0] MY_IDX = SEL_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (ctrl.op)
            CELL_INS: begin
                if (MY_IDX == ctrl.sel) begin
                    data_next = new_data;
                end else if (MY_IDX > ctrl.sel) begin
                    data_next = prev_data;
                end
            end
            CELL_DEL: begin
                if (MY_IDX >= ctrl.sel) begin
                    data_next = next_data;
                end
            end
            CELL_ROT: begin
                // head wraps around to the tail slot
                if (MY_IDX == ctrl.last) begin
                    data_next = head_data;
                end else if (MY_IDX < ctrl.last) begin
                    data_next = next_data;
                end
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

@@ hdl/plc_chain.sv @@
// Row of plc_cell instances linked to their neighbors, with the head tap
// and one indexed read port for the deleted entry.
// Depends on plc_pkg and plc_cell.
module plc_chain
    import plc_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     aclk,
    input  cell_ctrl_t               ctrl,
    input  logic [DATA_WIDTH-1:0]    new_data,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic [DATA_WIDTH-1:0]    rd_data,
    output logic [DATA_WIDTH-1:0]    head_data
);

    logic [DATA_WIDTH-1:0] cell_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_d;
        logic [DATA_WIDTH-1:0] next_d;

        if (i == 0) begin : g_first
            assign prev_d = new_data;
        end else begin : g_mid_prev
            assign prev_d = cell_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign next_d = cell_q[i];
        end else begin : g_mid_next
            assign next_d = cell_q[i+1];
        end

        plc_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .prev_data (prev_d),
            .next_data (next_d),
            .head_data (cell_q[0]),
            .new_data  (new_data),
            .data_out  (cell_q[i])
        );
    end

    assign head_data = cell_q[0];
    assign rd_data   = cell_q[rd_idx];

endmodule

@@ bench/list_result_checker.sv @@
// Result checker for the positional list engine: keeps its own copy of the list,
// predicts the result items of every accepted input item and compares them in order.
// Depends on plc_pkg for the operation and status codes.
`timescale 1ns / 100ps

module list_result_checker
    import plc_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [5:0]  s_position,
    input  logic [31:0] s_item_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_read_value,
    input  logic [4:0]  m_entry_total,
    input  logic        m_last_flag,
    output int          mismatch_count,
    output int          pending_results,
    output int          item_count,
    output int          result_count,
    output int          full_rejects,
    output int          full_dumps
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [4:0]  total;
        logic        last;
    } list_result_t;

    list_result_t expected_q[$];
    logic [31:0]  list_cells[DEPTH];
    int           list_len;
    int           reported;

    // entry_total is the length after the operation has been applied
    function automatic void queue_result(logic [1:0] status, logic [31:0] value, logic last);
        list_result_t r;
        r.status = status;
        r.value  = value;
        r.total  = list_len[4:0];
        r.last   = last;
        expected_q.push_back(r);
    endfunction

    function automatic void predict_item(logic [1:0] fn, logic [5:0] pos, logic [31:0] val);
        int p;
        int i;
        p = int'(pos);
        case (fn)
            FN_INSERT: begin
                // a full list rejects before the position is looked at
                if (list_len >= DEPTH) begin
                    full_rejects++;
                    queue_result(ST_FULL, '0, 1'b1);
                end else if (p < 1 || p > list_len + 1) begin
                    queue_result(ST_INVALID, '0, 1'b1);
                end else begin
                    for (i = list_len; i > p - 1; i--)
                        list_cells[i] = list_cells[i-1];
                    list_cells[p-1] = val;
                    list_len++;
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            FN_DELETE: begin
                if (p < 1 || p > list_len) begin
                    queue_result(ST_INVALID, '0, 1'b1);
                end else begin
                    logic [31:0] removed;
                    removed = list_cells[p-1];
                    for (i = p - 1; i + 1 < list_len; i++)
                        list_cells[i] = list_cells[i+1];
                    list_len--;
                    queue_result(ST_OK, removed, 1'b1);
                end
            end
            FN_DUMP: begin
                if (list_len == 0) begin
                    queue_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    if (list_len == DEPTH)
                        full_dumps++;
                    for (i = 0; i < list_len; i++)
                        queue_result(ST_OK, list_cells[i], i + 1 == list_len);
                end
            end
            default: queue_result(ST_INVALID, '0, 1'b1);
        endcase
    endfunction

    function automatic void check_result();
        list_result_t got;
        list_result_t want;
        got = '{m_status, m_read_value, m_entry_total, m_last_flag};
        result_count++;
        if (expected_q.size() == 0) begin
            mismatch_count++;
            if (reported < 10)
                $display("result %0d not expected: status %0d value %h total %0d last %b",
                         result_count, got.status, got.value, got.total, got.last);
            reported++;
        end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
                mismatch_count++;
                if (reported < 10) begin
                    $display("result %0d mismatch: want status %0d value %h total %0d last %b",
                             result_count, want.status, want.value, want.total, want.last);
                    $display("                    got  status %0d value %h total %0d last %b",
                             got.status, got.value, got.total, got.last);
                end
                reported++;
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_q.delete();
            list_len = 0;
        end else begin
            // predict before comparing so a same-edge result still finds its item
            if (s_valid && s_ready) begin
                item_count++;
                predict_item(s_func, s_position, s_item_value);
            end
            if (m_valid && m_ready)
                check_result();
        end
        pending_results <= expected_q.size();
    end

endmodule

@@ bench/positional_list_engine_unit_tb.sv @@
// Testbench top for positional_list_engine_unit: clock, reset, item stimulus and
// output stalls, with list_result_checker doing prediction and comparison.
// Depends on plc_pkg, list_result_checker and the block itself.
`timescale 1ns / 100ps

module positional_list_engine_unit_tb;
    import plc_pkg::*;

    localparam logic [1:0] FN_UNUSED  = 2'd3;
    localparam int LIST_DEPTH     = 16;
    localparam int ITEM_TOTAL     = 470;
    localparam int QUIET_TAIL     = 60;
    localparam int PHASE_LEN      = 60;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [5:0]  s_position;
    logic [31:0] s_item_value;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [31:0] m_read_value;
    logic [4:0]  m_entry_total;
    logic        m_last_flag;

    int mismatch_count;
    int pending_results;
    int item_count;
    int result_count;
    int full_rejects;
    int full_dumps;

    int sent_len;       // list length implied by the items sent so far
    int items_sent;
    bit quiet;
    bit hold_req;
    int hold_cycles;
    int stall_left;
    int idle_cycles;

    positional_list_engine_unit #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_position    (s_position),
        .s_item_value  (s_item_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_entry_total (m_entry_total),
        .m_last_flag   (m_last_flag)
    );

    list_result_checker #(
        .DEPTH (LIST_DEPTH)
    ) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_position      (s_position),
        .s_item_value    (s_item_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_read_value    (m_read_value),
        .m_entry_total   (m_entry_total),
        .m_last_flag     (m_last_flag),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .item_count      (item_count),
        .result_count    (result_count),
        .full_rejects    (full_rejects),
        .full_dumps      (full_dumps)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    task automatic send_item(input logic [1:0] fn, input logic [5:0] pos,
                             input logic [31:0] val);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= fn;
        s_position   <= pos;
        s_item_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (fn == FN_INSERT && sent_len < LIST_DEPTH && pos >= 1 && pos <= sent_len + 1)
            sent_len++;
        else if (fn == FN_DELETE && pos >= 1 && pos <= sent_len)
            sent_len--;
        items_sent++;
    endtask

    // mostly in-range positions so the list grows to full and drains to empty
    task automatic send_random(input bit grow);
        int         roll;
        int         ins_pct;
        int         del_pct;
        logic [1:0] fn;
        logic [5:0] pos;
        roll    = $urandom_range(0, 99);
        ins_pct = grow ? 65 : 25;
        del_pct = grow ? 12 : 50;
        if (roll < ins_pct) begin
            fn  = FN_INSERT;
            pos = 6'($urandom_range(1, sent_len + 1));
        end else if (roll < ins_pct + del_pct) begin
            fn  = FN_DELETE;
            pos = (sent_len == 0) ? 6'd1 : 6'($urandom_range(1, sent_len));
        end else if (roll < ins_pct + del_pct + 9) begin
            fn  = FN_DUMP;
            pos = 6'($urandom_range(0, 63));
        end else begin
            fn  = 2'($urandom_range(0, 3));
            pos = 6'($urandom_range(0, 63));
        end
        send_item(fn, pos, $urandom());
    endtask

    // output side: random stall bursts, one long hold-off, none in the tail
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_cycles = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("positional_list_engine_unit regression: fail");
        $finish;
    end

    initial begin
        int phase_items;
        bit grow;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_func       <= FN_INSERT;
        s_position   <= '0;
        s_item_value <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // empty list corner cases
        send_item(FN_DUMP,   6'd0,  32'h0000_0000);
        send_item(FN_DELETE, 6'd1,  32'h0000_0000);
        send_item(FN_DELETE, 6'd0,  32'hFFFF_FFFF);
        send_item(FN_INSERT, 6'd0,  32'h1111_1111);
        send_item(FN_INSERT, 6'd2,  32'h2222_2222);
        // insert at head, tail and middle
        send_item(FN_INSERT, 6'd1,  32'hFFFF_FFFF);
        send_item(FN_INSERT, 6'd2,  32'h0000_0000);
        send_item(FN_INSERT, 6'd1,  32'hA5A5_A5A5);
        send_item(FN_INSERT, 6'd2,  32'h5A5A_5A5A);
        send_item(FN_INSERT, 6'd63, 32'h1234_5678);
        send_item(FN_UNUSED, 6'd63, 32'hFFFF_FFFF);
        send_item(FN_DUMP,   6'd63, 32'hFFFF_FFFF);
        // delete at head, tail, out of range, then the tail again
        send_item(FN_DELETE, 6'd1,  32'h0000_0000);
        send_item(FN_DELETE, 6'd3,  32'h0000_0000);
        send_item(FN_DELETE, 6'd5,  32'h0000_0000);
        send_item(FN_DELETE, 6'd63, 32'h0000_0000);
        send_item(FN_DELETE, 6'd2,  32'h0000_0000);
        send_item(FN_DUMP,   6'd0,  32'h0000_0000);

        // the first random items meet a long output hold-off
        hold_req = 1'b1;
        phase_items = 0;
        grow = 1'b1;
        while (items_sent < ITEM_TOTAL) begin
            quiet = (items_sent >= ITEM_TOTAL - QUIET_TAIL);
            send_random(grow);
            phase_items++;
            if (phase_items == PHASE_LEN) begin
                phase_items = 0;
                grow = !grow;
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d items and %0d results, list cycled between empty and full",
                 item_count, result_count);
        $display("%0d inserts refused on a full list, %0d dumps of a full list",
                 full_rejects, full_dumps);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("positional_list_engine_unit regression: pass");
        end else begin
            $display("positional_list_engine_unit regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/plc_pkg.sv
hdl/plc_cell.sv
hdl/plc_chain.sv
hdl/positional_list_engine_unit.sv
bench/list_result_checker.sv
bench/positional_list_engine_unit_tb.sv
